// ===== hdl/psw_pkg.sv =====
`default_nettype none

package psw_pkg;

  // Fixed field widths
  localparam int unsigned TargetWidth  = 13;
  localparam int unsigned ClassWidth   = 2;
  localparam int unsigned CountsWidth  = 64;
  localparam int unsigned LaneStride   = 8;
  localparam int unsigned VswWidth     = 8;
  localparam int unsigned TswWidth     = 16;

  typedef logic signed [TargetWidth-1:0] target_t;
  typedef logic signed [ClassWidth-1:0]  class_t;
  typedef logic [VswWidth-1:0]           vsw_t;
  typedef logic [TswWidth-1:0]           tsw_t;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_EDGE  = 1'b1;

  // Player codes
  localparam logic PLAYER_MAX = 1'b0;
  localparam logic PLAYER_MIN = 1'b1;

  // Valuation classes (two's complement)
  localparam class_t CLASS_POS_INF = 2'sb01;
  localparam class_t CLASS_FINITE  = 2'sb00;
  localparam class_t CLASS_NEG_INF = 2'sb11;

  // Sink successor: all ones, i.e. -1
  localparam target_t SINK_TARGET = '1;

  localparam vsw_t VSW_MAX = '1;
  localparam tsw_t TSW_MAX = '1;

endpackage

`default_nettype wire

// ===== hdl/parity_strategy_switch_top.sv =====
`default_nettype none

// Strategy-switch step for parity-game strategy improvement, one vertex at a
// time. A start transaction (command 0) loads the vertex's current successor
// and its valuation as the best choice; each candidate-edge transaction
// (command 1) replaces the best choice only on a strict gain for the player
// held in the config register (0 maximises, 1 minimises). Valuations order
// plus infinity above finite above minus infinity; two finite ones are decided
// by the highest differing priority lane, larger better at even priority and
// smaller better at odd. A sink target (-1) always counts as finite, all
// counts zero; class pattern 2'b10 reads as minus infinity. The transaction
// flagged last produces one result: chosen successor, saturating switch count
// for the vertex and saturating running total since reset. Throughput is one
// transaction per cycle while the input is not stalled: items are registered
// on entry, then compared against the held best choice and folded into it as
// the staged item advances; a last item loads its result into the output
// register in that same step. The only loop is best-state update, closed
// within that compare step. Input stalls only while a result is held on the
// output and the next staged item is itself a last one.
// Write the player register only while no transaction is in flight.
module parity_strategy_switch_top #(
  parameter int unsigned PRIORITY_LEVELS = 8,  // lanes compared, 2..8
  parameter int unsigned COUNT_BITS      = 8   // bits kept per lane, 4..8
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // config
  input  wire                                   cfg_we_i,
  input  wire                                   cfg_wdata_i,
  // input channel
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire                                   command_i,
  input  wire signed [psw_pkg::TargetWidth-1:0] target_i,
  input  wire signed [psw_pkg::ClassWidth-1:0]  target_class_i,
  input  wire        [psw_pkg::CountsWidth-1:0] target_counts_i,
  input  wire                                   last_i,
  // result channel
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic signed [psw_pkg::TargetWidth-1:0] chosen_target_o,
  output logic        [psw_pkg::VswWidth-1:0]    vertex_switches_o,
  output logic        [psw_pkg::TswWidth-1:0]    total_switches_o
);

  typedef logic [PRIORITY_LEVELS-1:0][COUNT_BITS-1:0] lanes_t;

  // ---------------------------------------------------------------------
  // Config register
  // ---------------------------------------------------------------------
  logic player_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_q <= psw_pkg::PLAYER_MAX;
    end else if (cfg_we_i) begin
      player_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------
  // Entry stage: decode class, apply sink rule, mask lanes
  // ---------------------------------------------------------------------
  logic             s1_valid_q;
  logic             s1_cmd_q;
  psw_pkg::target_t s1_target_q;
  psw_pkg::class_t  s1_class_q;
  lanes_t           s1_lanes_q;
  logic             s1_last_q;

  psw_pkg::class_t  in_class;
  lanes_t           in_lanes;
  logic             in_sink;
  logic             s1_adv;
  logic             in_fire;

  always_comb begin
    in_sink = (target_i == psw_pkg::SINK_TARGET);
    case (target_class_i)
      psw_pkg::CLASS_POS_INF: in_class = psw_pkg::CLASS_POS_INF;
      psw_pkg::CLASS_FINITE:  in_class = psw_pkg::CLASS_FINITE;
      default:                in_class = psw_pkg::CLASS_NEG_INF;
    endcase
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      in_lanes[i] = target_counts_i[i*psw_pkg::LaneStride +: COUNT_BITS];
    end
    if (in_sink) begin
      in_class = psw_pkg::CLASS_FINITE;
      in_lanes = '0;
    end
  end

  // Staged item moves on unless it is a last one and the result slot is full and not being read
  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q    <= command_i;
      s1_target_q <= target_i;
      s1_class_q  <= in_class;
      s1_lanes_q  <= in_lanes;
      s1_last_q   <= last_i;
    end
  end

  // ---------------------------------------------------------------------
  // Best choice and counters
  // ---------------------------------------------------------------------
  psw_pkg::target_t best_target_q, best_target_d;
  psw_pkg::class_t  best_class_q,  best_class_d;
  lanes_t           best_lanes_q,  best_lanes_d;
  psw_pkg::vsw_t    vsw_q, vsw_d;
  psw_pkg::tsw_t    tsw_q, tsw_d;

  logic above;
  logic below;
  logic differ;
  logic gain;

  // Candidate vs best: highest differing lane wins, so later lanes overwrite
  always_comb begin
    above  = 1'b0;
    differ = 1'b0;
    if (s1_class_q != psw_pkg::CLASS_FINITE || best_class_q != psw_pkg::CLASS_FINITE) begin
      above  = (s1_class_q > best_class_q);
      differ = (s1_class_q != best_class_q);
    end else begin
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        if (s1_lanes_q[i] != best_lanes_q[i]) begin
          differ = 1'b1;
          above  = (i % 2 == 0) ? (s1_lanes_q[i] > best_lanes_q[i])
                                : (s1_lanes_q[i] < best_lanes_q[i]);
        end
      end
    end
    below = differ && !above;
    gain  = (player_q == psw_pkg::PLAYER_MIN) ? below : above;
  end

  always_comb begin
    best_target_d = best_target_q;
    best_class_d  = best_class_q;
    best_lanes_d  = best_lanes_q;
    vsw_d         = vsw_q;
    tsw_d         = tsw_q;
    if (s1_adv) begin
      if (s1_cmd_q == psw_pkg::CMD_START) begin
        best_target_d = s1_target_q;
        best_class_d  = s1_class_q;
        best_lanes_d  = s1_lanes_q;
        vsw_d         = '0;
      end else if (gain) begin
        best_target_d = s1_target_q;
        best_class_d  = s1_class_q;
        best_lanes_d  = s1_lanes_q;
        if (vsw_q != psw_pkg::VSW_MAX) vsw_d = vsw_q + 1'b1;
        if (tsw_q != psw_pkg::TSW_MAX) tsw_d = tsw_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_target_q <= psw_pkg::SINK_TARGET;
      best_class_q  <= psw_pkg::CLASS_FINITE;
      best_lanes_q  <= '0;
      vsw_q         <= '0;
      tsw_q         <= '0;
    end else begin
      best_target_q <= best_target_d;
      best_class_q  <= best_class_d;
      best_lanes_q  <= best_lanes_d;
      vsw_q         <= vsw_d;
      tsw_q         <= tsw_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic res_load;

  assign res_load = s1_adv && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (res_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      chosen_target_o   <= best_target_d;
      vertex_switches_o <= vsw_d;
      total_switches_o  <= tsw_d;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Running total only ever grows
  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> tsw_q >= $past(tsw_q))
    else $error("total switch count went down");

  // Per-vertex count can never exceed the running total
  a_vertex_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psw_pkg::TswWidth'(vsw_q) <= tsw_q)
    else $error("vertex switch count above total");

  // An empty entry stage always takes a new transaction
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("entry stage empty but not ready");

  // A staged item that cannot advance is held, not dropped
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_target_q))
    else $error("staged transaction lost while stalled");

  // Best state changes only when a staged item advances
  a_best_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(best_target_q) && $stable(vsw_q))
    else $error("best choice changed without a transaction");

endmodule

`default_nettype wire

// ===== tb/psw_tb_pkg.sv =====
`timescale 1ns / 1ps

package psw_tb_pkg;
  import psw_pkg::*;

  localparam int unsigned LANES     = 8;
  localparam int unsigned LANE_BITS = 8;

  // class pattern 2'b10, read as minus infinity
  localparam class_t CLASS_NEG_ALT = 2'sb10;

  typedef struct {
    logic                   cmd;
    target_t                tgt;
    class_t                 cls;
    logic [CountsWidth-1:0] cnt;
    logic                   last;
  } feed_t;

  typedef struct {
    target_t tgt;
    vsw_t    vsw;
    tsw_t    tsw;
  } choice_t;

  class switch_scoreboard;
    logic                   player;
    target_t                best_tgt;
    int                     best_cls;
    logic [CountsWidth-1:0] best_cnt;
    vsw_t                   vsw_cnt;
    tsw_t                   tsw_cnt;
    choice_t                pending_choices[$];
    int unsigned            errors;
    int unsigned            accepted;
    int unsigned            checked;
    int unsigned            replacements;

    function new();
      player       = PLAYER_MAX;
      best_tgt     = SINK_TARGET;
      best_cls     = 0;
      best_cnt     = '0;
      vsw_cnt      = '0;
      tsw_cnt      = '0;
      errors       = 0;
      accepted     = 0;
      checked      = 0;
      replacements = 0;
    endfunction

    static function int decode_class(class_t raw);
      if (raw == CLASS_POS_INF) return 1;
      if (raw == CLASS_FINITE) return 0;
      return -1;
    endfunction

    // +1 when a is above b, -1 when below, 0 when level
    static function int rank(int ac, logic [CountsWidth-1:0] an,
                             int bc, logic [CountsWidth-1:0] bn);
      logic [LANE_BITS-1:0] x;
      logic [LANE_BITS-1:0] y;
      if (ac != 0 || bc != 0) begin
        if (ac > bc) return 1;
        if (ac < bc) return -1;
        return 0;
      end
      for (int p = LANES - 1; p >= 0; p--) begin
        x = an[p*LaneStride +: LANE_BITS];
        y = bn[p*LaneStride +: LANE_BITS];
        if (x != y) begin
          if (p % 2 == 0) return (x > y) ? 1 : -1;
          return (x < y) ? 1 : -1;
        end
      end
      return 0;
    endfunction

    function void note_item(feed_t f);
      int                     cls;
      int                     r;
      bit                     gain;
      logic [CountsWidth-1:0] cnt;
      choice_t                c;
      accepted++;
      cls = decode_class(f.cls);
      cnt = f.cnt;
      if (f.tgt == SINK_TARGET) begin
        cls = 0;
        cnt = '0;
      end
      if (f.cmd == CMD_START) begin
        best_tgt = f.tgt;
        best_cls = cls;
        best_cnt = cnt;
        vsw_cnt  = '0;
      end else begin
        r    = rank(cls, cnt, best_cls, best_cnt);
        gain = (player == PLAYER_MAX) ? (r == 1) : (r == -1);
        if (gain) begin
          best_tgt = f.tgt;
          best_cls = cls;
          best_cnt = cnt;
          if (vsw_cnt != VSW_MAX) vsw_cnt++;
          if (tsw_cnt != TSW_MAX) tsw_cnt++;
          replacements++;
        end
      end
      if (f.last) begin
        c.tgt = best_tgt;
        c.vsw = vsw_cnt;
        c.tsw = tsw_cnt;
        pending_choices = {pending_choices, c};
      end
    endfunction

    function void check_result(target_t tgt, vsw_t vsw, tsw_t tsw);
      choice_t c;
      if (pending_choices.size() == 0) begin
        errors++;
        $display("%0t: result with none pending: target %0d vsw %0d tsw %0d",
                 $time, tgt, vsw, tsw);
        return;
      end
      c = pending_choices.pop_front();
      checked++;
      if (tgt !== c.tgt) begin
        errors++;
        $display("%0t: chosen_target expected %0d actual %0d", $time, c.tgt, tgt);
      end
      if (vsw !== c.vsw) begin
        errors++;
        $display("%0t: vertex_switches expected %0d actual %0d", $time, c.vsw, vsw);
      end
      if (tsw !== c.tsw) begin
        errors++;
        $display("%0t: total_switches expected %0d actual %0d", $time, c.tsw, tsw);
      end
    endfunction

    function int unsigned outstanding();
      return pending_choices.size();
    endfunction
  endclass

endpackage

// ===== tb/parity_strategy_switch_top_tb.sv =====
`timescale 1ns / 1ps

// Strategy-switch regression: directed transactions for both players and the
// odd cases (sink, class 2'b10, no start, start flagged last, wide targets),
// random vertex streams with noise, a long output hold-off and a ramp that
// saturates the per-vertex switch counter.
module parity_strategy_switch_top_tb;
  import psw_pkg::*;
  import psw_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned RAMP_EDGES    = 260;  // past the vertex counter's ceiling
  localparam int unsigned SETTLE_CYCLES = 6;    // entry and result registers plus margin

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic                   cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   command_i;
  target_t                target_i;
  class_t                 target_class_i;
  logic [CountsWidth-1:0] target_counts_i;
  logic                   last_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  target_t                chosen_target_o;
  vsw_t                   vertex_switches_o;
  tsw_t                   total_switches_o;

  switch_scoreboard sb;

  // sender pacing
  bit          pacing_on;
  int unsigned burst_left;
  // long hold-off requests, served by the receiver process
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned cycle_count;

  parity_strategy_switch_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .target_i         (target_i),
    .target_class_i   (target_class_i),
    .target_counts_i  (target_counts_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .chosen_target_o  (chosen_target_o),
    .vertex_switches_o(vertex_switches_o),
    .total_switches_o (total_switches_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: any hang ends the run as a failure.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("parity_strategy_switch_top regression: fail");
      $finish;
    end
  end

  // Result monitor: every accepted result is checked against the oldest
  // pending choice.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(chosen_target_o, vertex_switches_o, total_switches_o);
  end

  // Receiver: switches between always ready, coin-toss and mostly stalled in
  // random stretches; a pending hold-off request drops ready for a long run.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    out_ready_i = 1'b0;
    hold_served = 0;
    mode        = 0;
    mode_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_served++;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          0: begin
            out_ready_i <= 1'b1;
          end
          1: begin
            out_ready_i <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_ready_i <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  function automatic feed_t feed(logic cmd, target_t tgt, class_t cls,
                                 logic [CountsWidth-1:0] cnt, logic last);
    feed_t f;
    f.cmd  = cmd;
    f.tgt  = tgt;
    f.cls  = cls;
    f.cnt  = cnt;
    f.last = last;
    return f;
  endfunction

  // Mostly ordinary vertices, with some sink and out-of-range numbers.
  function automatic target_t any_target();
    case ($urandom_range(0, 9))
      0: return SINK_TARGET;
      1: return target_t'($urandom_range(4096, 8190));
      default: return target_t'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic class_t any_class();
    case ($urandom_range(0, 9))
      0: return CLASS_POS_INF;
      1: return CLASS_NEG_INF;
      2: return CLASS_NEG_ALT;
      default: return CLASS_FINITE;
    endcase
  endfunction

  // Small lane values make ties in the high lanes common, so the lower
  // lanes get to decide; full random words cover every bit.
  function automatic logic [CountsWidth-1:0] any_counts();
    logic [CountsWidth-1:0] c;
    c = '0;
    case ($urandom_range(0, 5))
      0: c = {$urandom, $urandom};
      1: c = '1;
      default: begin
        for (int p = 0; p < LANES; p++)
          c[p*LaneStride +: LANE_BITS] = LANE_BITS'($urandom_range(0, 2));
      end
    endcase
    return c;
  endfunction

  // Burst pacing: a random gap at the start of each burst, sometimes none.
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (pacing_on && gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
  endtask

  // Presents one transaction from a falling edge and holds it until taken.
  task automatic offer(feed_t f);
    pace();
    in_valid_i      <= 1'b1;
    command_i       <= f.cmd;
    target_i        <= f.tgt;
    target_class_i  <= f.cls;
    target_counts_i <= f.cnt;
    last_i          <= f.last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(f);
    @(negedge clk_i);
  endtask

  // Stop sending and let every pending result drain, plus the pipe depth
  // so that trailing transactions without a result have settled too.
  task automatic rest();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_player(logic p);
    rest();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= p;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.player = p;
  endtask

  // Mostly well-formed vertices; the rest are stray edges, vertices that
  // never close, and single transactions with every field random.
  task automatic offer_random_vertex();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    n    = $urandom_range(0, 8);
    if (kind < 80) begin
      offer(feed(CMD_START, any_target(), any_class(), any_counts(), n == 0));
      for (int unsigned i = 1; i <= n; i++)
        offer(feed(CMD_EDGE, any_target(), any_class(), any_counts(), i == n));
    end else if (kind < 88) begin
      n = $urandom_range(1, 3);
      for (int unsigned i = 1; i <= n; i++)
        offer(feed(CMD_EDGE, any_target(), any_class(), any_counts(), i == n));
    end else if (kind < 94) begin
      offer(feed(CMD_START, any_target(), any_class(), any_counts(), 1'b0));
      for (int unsigned i = 1; i <= n; i++)
        offer(feed(CMD_EDGE, any_target(), any_class(), any_counts(), 1'b0));
    end else begin
      offer(feed(1'($urandom_range(0, 1)), any_target(), any_class(), any_counts(),
                 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic random_phase(int unsigned items);
    int unsigned goal;
    goal = sb.accepted + items;
    while (sb.accepted < goal) offer_random_vertex();
  endtask

  initial begin
    logic [23:0]            step;
    logic [CountsWidth-1:0] ramp_cnt;
    sb              = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 1'b0;
    in_valid_i      = 1'b0;
    command_i       = CMD_START;
    target_i        = '0;
    target_class_i  = CLASS_FINITE;
    target_counts_i = '0;
    last_i          = 1'b0;
    pacing_on       = 1'b1;
    burst_left      = 0;
    hold_requests   = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // --- directed, maximising player ---
    set_player(PLAYER_MAX);
    // edge with no start: judged against the reset best, the sink
    offer(feed(CMD_EDGE, 13'sd5, CLASS_FINITE, 64'h1, 1'b1));
    offer(feed(CMD_START, 13'sd7, CLASS_FINITE, 64'h100, 1'b0));
    // fewer at an odd priority wins
    offer(feed(CMD_EDGE, 13'sd8, CLASS_FINITE, 64'h0, 1'b0));
    // sink: class and counts ignored, level with the best, so no switch
    offer(feed(CMD_EDGE, SINK_TARGET, CLASS_POS_INF, '1, 1'b0));
    // class 2'b10 is minus infinity
    offer(feed(CMD_EDGE, 13'sd9, CLASS_NEG_ALT, any_counts(), 1'b0));
    offer(feed(CMD_EDGE, 13'h1FFE, CLASS_POS_INF, 64'h0, 1'b0));
    // equal plus infinity: no strict gain
    offer(feed(CMD_EDGE, 13'sd10, CLASS_POS_INF, '1, 1'b1));
    // start flagged last: reported at once, no switches
    offer(feed(CMD_START, 13'h1000, CLASS_NEG_INF, '1, 1'b1));
    offer(feed(CMD_START, 13'sd0, CLASS_FINITE, '1, 1'b0));
    offer(feed(CMD_EDGE, 13'sd4095, CLASS_FINITE, 64'hFEFF_FFFF_FFFF_FFFF, 1'b0));
    offer(feed(CMD_EDGE, 13'sd1, CLASS_FINITE, 64'h0, 1'b0));
    offer(feed(CMD_EDGE, 13'sd2, CLASS_NEG_INF, 64'h0, 1'b0));
    offer(feed(CMD_EDGE, 13'sd3, CLASS_FINITE, 64'h0001_0000_0000_0000, 1'b1));

    // --- directed, minimising player ---
    set_player(PLAYER_MIN);
    offer(feed(CMD_START, 13'sd20, CLASS_FINITE, 64'h5, 1'b0));
    offer(feed(CMD_EDGE, 13'sd21, CLASS_FINITE, 64'h4, 1'b0));
    offer(feed(CMD_EDGE, 13'sd22, CLASS_POS_INF, 64'h0, 1'b0));
    offer(feed(CMD_EDGE, 13'sd23, CLASS_NEG_ALT, 64'h0, 1'b0));
    offer(feed(CMD_EDGE, SINK_TARGET, CLASS_FINITE, 64'h0, 1'b1));
    offer(feed(CMD_START, SINK_TARGET, CLASS_POS_INF, '1, 1'b0));
    // more at an odd priority is lower, so a gain for the minimiser
    offer(feed(CMD_EDGE, 13'sd30, CLASS_FINITE, 64'h0100_0000, 1'b1));

    // --- random vertex streams across both players ---
    random_phase(70);
    set_player(PLAYER_MAX);
    random_phase(70);

    // Long output hold-off while starts flagged last keep coming: results
    // back up and the input has to stall.
    rest();
    pacing_on = 1'b0;
    hold_requests++;
    repeat (40) offer(feed(CMD_START, any_target(), any_class(), any_counts(), 1'b1));
    pacing_on = 1'b1;

    set_player(PLAYER_MIN);
    random_phase(70);

    // Saturation ramp: one vertex whose every edge is strictly better than
    // the one before (even lanes 0, 2 and 4 carry a rising step count).
    set_player(PLAYER_MAX);
    pacing_on = 1'b0;
    offer(feed(CMD_START, 13'sd100, CLASS_NEG_INF, 64'h0, 1'b0));
    for (int unsigned k = 1; k <= RAMP_EDGES; k++) begin
      step     = k[23:0];
      ramp_cnt = '0;
      ramp_cnt[7:0]   = step[7:0];
      ramp_cnt[23:16] = step[15:8];
      ramp_cnt[39:32] = step[23:16];
      offer(feed(CMD_EDGE, target_t'(k % 4096), CLASS_FINITE, ramp_cnt, k == RAMP_EDGES));
    end
    // next vertex starts its own count afresh while the total carries on
    offer(feed(CMD_START, 13'sd1, CLASS_FINITE, 64'h0, 1'b0));
    offer(feed(CMD_EDGE, 13'sd2, CLASS_POS_INF, 64'h0, 1'b1));
    pacing_on = 1'b1;
    random_phase(20);

    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d transactions in, %0d results checked, %0d switches.",
             sb.accepted, sb.checked, sb.replacements);
    $display("Both players, sink and class corner cases, output back-pressure and "
             , "per-vertex counter saturation exercised.");
    if (sb.errors == 0) begin
      $display("parity_strategy_switch_top regression: pass");
    end else begin
      $display("parity_strategy_switch_top regression: fail");
    end
    $finish;
  end

endmodule
